@@ rtl/qmld_pkg.sv @@
// Package for the QAM max-log soft demapper: word types, field widths,
// LLR constants and the state encodings. It depends on nothing else.
package qmld_pkg;

   localparam int FIELD_W   = 16;
   localparam int INDEX_W   = 6;
   localparam int LABEL_W   = 6;
   localparam int BIT_IDX_W = 3;
   localparam int LLR_W     = 24;
   localparam int SCALE_W   = 24;
   localparam int ORDER_W   = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // The scaler clips the distance difference to MAG_W bits and multiplies it
   // in two partial products, the low one SPLIT_W bits wide.
   localparam int MAG_W     = 39;
   localparam int SPLIT_W   = 20;
   localparam int PP_W      = SPLIT_W + SCALE_W;
   localparam int PROD_W    = MAG_W + SCALE_W;
   localparam int LLR_SHIFT = 16;

   localparam logic [LLR_W-1:0] LLR_POS_MAX = 24'h7FFFFF;
   localparam logic [LLR_W-1:0] LLR_NEG_MAX = 24'h800000;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_DEMOD = 1'b1;

   localparam logic [1:0] REG_ORDER_LOG2 = 2'd0;
   localparam logic [1:0] REG_DEMOD_MODE = 2'd1;
   localparam logic [1:0] REG_LLR_SCALE  = 2'd2;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

   typedef struct packed {
      logic                       req_type;
      logic [INDEX_W-1:0]         point_index;
      logic signed [FIELD_W-1:0]  point_i;
      logic signed [FIELD_W-1:0]  point_q;
      logic [LABEL_W-1:0]         point_label;
      logic signed [FIELD_W-1:0]  rx_i;
      logic signed [FIELD_W-1:0]  rx_q;
   } req_word_type;

   typedef struct packed {
      logic [BIT_IDX_W-1:0]    bit_index;
      logic                    hard_bit;
      logic signed [LLR_W-1:0] llr;
      logic                    last_bit;
   } rsp_word_type;

   // Travels with each point through the read and distance pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } qmld_tag_type;

   typedef struct packed {
      logic             done;
      logic             hard;
      logic [LLR_W-1:0] llr;
   } qmld_llr_res_type;

   typedef enum logic [1:0] {
      LK_CALC,
      LK_POS,
      LK_NEG,
      LK_ZERO
   } qmld_llr_kind_type;

   typedef enum logic [2:0] {
      LS_IDLE,
      LS_LO,
      LS_HI,
      LS_SUM,
      LS_OUT
   } qmld_llr_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_LLR_START,
      ST_LLR_WAIT,
      ST_PUT
   } qmld_state_type;

endpackage

@@ rtl/qmld_point_table.sv @@
// Constellation point table: one write port, one registered read port.
// Depends on nothing but its parameters.
module qmld_point_table #(
   parameter int AW = 6,
   parameter int TW = 38
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [TW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [TW-1:0] rd_data
);

   logic [TW-1:0] mem [2**AW];
   logic [TW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/qmld_dist_unit.sv @@
// Three-stage squared Euclidean distance pipeline, one point per cycle.
// Uses qmld_pkg for the pipeline tag.
module qmld_dist_unit import qmld_pkg::*; #(
   parameter int SW = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  qmld_tag_type       in_tag,
   input  logic [SW-1:0]      in_pt_i,
   input  logic [SW-1:0]      in_pt_q,
   input  logic [SW-1:0]      in_rx_i,
   input  logic [SW-1:0]      in_rx_q,
   input  logic [LABEL_W-1:0] in_label,
   output qmld_tag_type       out_tag,
   output logic [2*SW:0]      out_dist,
   output logic [LABEL_W-1:0] out_label
);

   qmld_tag_type       tag1_ff, tag2_ff, tag3_ff;
   logic [LABEL_W-1:0] lab1_ff, lab2_ff, lab3_ff;
   logic [SW-1:0]      abs_i_ff, abs_q_ff;
   logic [2*SW-1:0]    sq_i_ff, sq_q_ff;
   logic [2*SW:0]      dist_ff;
   logic [SW:0]        diff_i, diff_q;
   logic [SW-1:0]      abs_i_in, abs_q_in;

   always_comb begin
      diff_i = {in_pt_i[SW-1], in_pt_i} - {in_rx_i[SW-1], in_rx_i};
      diff_q = {in_pt_q[SW-1], in_pt_q} - {in_rx_q[SW-1], in_rx_q};
      // The difference magnitude is below 2^SW, so it fits SW bits.
      abs_i_in = diff_i[SW] ? SW'(-diff_i) : diff_i[SW-1:0];
      abs_q_in = diff_q[SW] ? SW'(-diff_q) : diff_q[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      abs_i_ff <= abs_i_in;
      abs_q_ff <= abs_q_in;
      lab1_ff  <= in_label;
      sq_i_ff  <= abs_i_ff * abs_i_ff;
      sq_q_ff  <= abs_q_ff * abs_q_ff;
      lab2_ff  <= lab1_ff;
      dist_ff  <= {1'b0, sq_i_ff} + {1'b0, sq_q_ff};
      lab3_ff  <= lab2_ff;
   end

   assign out_tag   = tag3_ff;
   assign out_dist  = dist_ff;
   assign out_label = lab3_ff;

endmodule

@@ rtl/qmld_llr_unit.sv @@
// LLR scaler: difference of the two minima times the Q8.16 scale, with
// rounding toward minus infinity and saturation, on one shared multiplier.
// Uses qmld_pkg for widths, constants and step encodings.
module qmld_llr_unit import qmld_pkg::*; #(
   parameter int DW = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DW-1:0]      min0,
   input  logic [DW-1:0]      min1,
   input  logic               valid0,
   input  logic               valid1,
   input  logic [SCALE_W-1:0] scale,
   output qmld_llr_res_type   res
);

   localparam int MW = (DW > MAG_W + 1) ? DW : MAG_W + 1;
   localparam int QW = PROD_W - LLR_SHIFT;

   qmld_llr_step_type step_ff, step_in;
   qmld_llr_kind_type kind_ff, kind_in;
   logic              neg_ff, hard_ff, hard_in, done_ff, done_in;
   logic [MAG_W-1:0]  mag_ff;
   logic [PP_W-1:0]   pp_lo_ff, pp_hi_ff, pp;
   logic [PROD_W-1:0] prod_ff;
   logic [LLR_W-1:0]  llr_ff, llr_in;
   logic [DW-1:0]     diff;
   logic [MW-1:0]     mag_x;
   logic              gt, lt, over;
   logic [SPLIT_W-1:0] mul_a;
   logic [QW-1:0]     q;
   logic [QW:0]       qn;

   always_comb begin
      gt    = min0 > min1;
      lt    = min1 > min0;
      diff  = lt ? (min1 - min0) : (min0 - min1);
      mag_x = MW'(diff);
      over  = |mag_x[MW-1:MAG_W];
      if (!valid1) begin
         kind_in = LK_NEG;
         hard_in = 1'b0;
      end else if (!valid0) begin
         kind_in = LK_POS;
         hard_in = 1'b1;
      end else begin
         hard_in = gt;
         if (scale == '0) begin
            kind_in = LK_ZERO;
         end else if (over) begin
            kind_in = lt ? LK_NEG : LK_POS;
         end else begin
            kind_in = LK_CALC;
         end
      end
   end

   // The one multiplier takes the low part of the magnitude first, then the high part.
   always_comb begin
      if (step_ff == LS_LO) begin
         mul_a = mag_ff[SPLIT_W-1:0];
      end else begin
         mul_a = SPLIT_W'(mag_ff[MAG_W-1:SPLIT_W]);
      end
      pp = PP_W'(mul_a * scale);
   end

   always_comb begin
      q  = prod_ff[PROD_W-1:LLR_SHIFT];
      qn = (QW + 1)'(q) + (QW + 1)'(|prod_ff[LLR_SHIFT-1:0]);
      case (kind_ff)
         LK_POS:  llr_in = LLR_POS_MAX;
         LK_NEG:  llr_in = LLR_NEG_MAX;
         LK_ZERO: llr_in = '0;
         default: begin
            if (neg_ff) begin
               llr_in = (qn > (QW + 1)'(LLR_NEG_MAX)) ? LLR_NEG_MAX
                                                     : LLR_W'((QW + 1)'(0) - qn);
            end else begin
               llr_in = (q > QW'(LLR_POS_MAX)) ? LLR_POS_MAX : q[LLR_W-1:0];
            end
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      case (step_ff)
         LS_IDLE: if (start) step_in = LS_LO;
         LS_LO:   step_in = LS_HI;
         LS_HI:   step_in = LS_SUM;
         LS_SUM:  step_in = LS_OUT;
         LS_OUT: begin
            step_in = LS_IDLE;
            done_in = 1'b1;
         end
         default: step_in = LS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= LS_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff == LS_IDLE && start) begin
         kind_ff <= kind_in;
         hard_ff <= hard_in;
         neg_ff  <= lt;
         mag_ff  <= mag_x[MAG_W-1:0];
      end
      if (step_ff == LS_LO) pp_lo_ff <= pp;
      if (step_ff == LS_HI) pp_hi_ff <= pp;
      if (step_ff == LS_SUM) begin
         prod_ff <= PROD_W'(pp_lo_ff) + (PROD_W'(pp_hi_ff) << SPLIT_W);
      end
      if (step_ff == LS_OUT) llr_ff <= llr_in;
   end

   assign res.done = done_ff;
   assign res.hard = hard_ff;
   assign res.llr  = llr_ff;

endmodule

@@ rtl/qam_max_log_soft_demapper.sv @@
// Max-log QAM soft demapper. A load word (req_type 0) writes one point of the
// constellation table and returns nothing. A demodulate word (req_type 1) is
// followed by a scan that reads one table point per cycle through the single
// read port and a three-stage distance pipeline, tracking per-bit minima and
// the nearest point. Each of the order result words then goes through the LLR
// scaler, whose one multiplier forms the product in two partial steps; the
// block holds req_ready low until the last result word of a demodulate word
// is loaded. The last result word sits in an output register, so the next
// word is taken while it waits. The table has no reset; entries inside the
// searched range must be loaded before a sample is demodulated. Registers:
// order_log2 at 0x0, demod_mode at 0x4, llr_scale at 0x8, to be written by the
// user only while the block is idle; the block itself does not enforce this.
// Uses qmld_pkg, qmld_point_table, qmld_dist_unit and qmld_llr_unit.
module qam_max_log_soft_demapper import qmld_pkg::*; #(
   parameter int MAX_BITS     = 6,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int AW  = MAX_BITS;
   localparam int DW  = 2 * SW + 1;
   localparam int TW  = 2 * SW + LABEL_W;
   localparam int IW  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam int OW  = $clog2(MAX_BITS + 1);
   localparam int LBW = (MAX_BITS > LABEL_W) ? MAX_BITS : LABEL_W;

   // Configuration registers
   logic [ORDER_W-1:0] order_ff;
   logic               mode_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         mode_ff  <= 1'b0;
         scale_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ORDER_LOG2: order_ff <= csr_pwdata[ORDER_W-1:0];
            REG_DEMOD_MODE: mode_ff  <= csr_pwdata[0];
            REG_LLR_SCALE:  scale_ff <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ORDER_LOG2: csr_prdata = CSR_DATA_W'(order_ff);
         REG_DEMOD_MODE: csr_prdata = CSR_DATA_W'(mode_ff);
         REG_LLR_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Effective order, clamped to 1 .. MAX_BITS
   logic [3:0]    cfg4, lim4, ord4;
   logic [OW-1:0] ord_c;

   always_comb begin
      cfg4 = 4'(order_ff);
      lim4 = 4'(MAX_BITS);
      if (cfg4 == 4'd0) begin
         ord4 = 4'd1;
      end else if (cfg4 > lim4) begin
         ord4 = lim4;
      end else begin
         ord4 = cfg4;
      end
      ord_c = OW'(ord4);
   end

   // Sequencer and scan state
   qmld_state_type     state_ff, state_in;
   logic [OW-1:0]      ord_ff, ord_in;
   logic [AW-1:0]      cnt_ff, cnt_in, last_addr;
   logic [IW-1:0]      bit_ff, bit_in, pos_c;
   logic [SW-1:0]      rx_i_ff, rx_q_ff;
   qmld_tag_type       rd_tag_ff, rd_tag_in;
   logic               rd_en, llr_start, clear_mins, load_rsp, last_bit_c;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign last_addr = {AW{1'b1}} >> (OW'(MAX_BITS) - ord_ff);
   assign pos_c     = IW'(ord_ff - OW'(1) - OW'(bit_ff));
   assign last_bit_c = (OW'(bit_ff) == ord_ff - OW'(1));

   // Table
   logic [TW-1:0]      wr_word, rd_word;
   logic [SW-1:0]      ld_i, ld_q;

   assign ld_i    = SW'($unsigned(req_data.point_i));
   assign ld_q    = SW'($unsigned(req_data.point_q));
   assign wr_word = {req_data.point_label, ld_q, ld_i};

   qmld_point_table #(.AW(AW), .TW(TW)) u_table (
      .clock   (clock),
      .wr_en   (accept && req_data.req_type == REQ_LOAD),
      .wr_addr (AW'(req_data.point_index)),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_word)
   );

   // Distance pipeline
   qmld_tag_type       d_tag;
   logic [DW-1:0]      d_dist;
   logic [LABEL_W-1:0] d_label;

   qmld_dist_unit #(.SW(SW)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (rd_tag_ff),
      .in_pt_i   (rd_word[SW-1:0]),
      .in_pt_q   (rd_word[2*SW-1:SW]),
      .in_rx_i   (rx_i_ff),
      .in_rx_q   (rx_q_ff),
      .in_label  (rd_word[TW-1:2*SW]),
      .out_tag   (d_tag),
      .out_dist  (d_dist),
      .out_label (d_label)
   );

   // Minima, indexed by label bit position, and the nearest point
   logic [DW-1:0]       min0_ff [MAX_BITS];
   logic [DW-1:0]       min1_ff [MAX_BITS];
   logic [DW-1:0]       min0_in [MAX_BITS];
   logic [DW-1:0]       min1_in [MAX_BITS];
   logic [MAX_BITS-1:0] v0_ff, v1_ff, v0_in, v1_in;
   logic [DW-1:0]       best_ff, best_in;
   logic                best_v_ff, best_v_in;
   logic [LABEL_W-1:0]  near_ff, near_in;
   logic [LBW-1:0]      lab_x, near_x;

   always_comb begin
      lab_x     = LBW'(d_label);
      min0_in   = min0_ff;
      min1_in   = min1_ff;
      v0_in     = v0_ff;
      v1_in     = v1_ff;
      best_in   = best_ff;
      best_v_in = best_v_ff;
      near_in   = near_ff;
      if (clear_mins) begin
         v0_in     = '0;
         v1_in     = '0;
         best_v_in = 1'b0;
      end else if (d_tag.valid) begin
         if (!best_v_ff || d_dist < best_ff) begin
            best_in   = d_dist;
            best_v_in = 1'b1;
            near_in   = d_label;
         end
         for (int k = 0; k < MAX_BITS; k++) begin
            if (k < int'(ord_ff)) begin
               if (lab_x[k]) begin
                  if (!v1_ff[k] || d_dist < min1_ff[k]) begin
                     min1_in[k] = d_dist;
                     v1_in[k]   = 1'b1;
                  end
               end else begin
                  if (!v0_ff[k] || d_dist < min0_ff[k]) begin
                     min0_in[k] = d_dist;
                     v0_in[k]   = 1'b1;
                  end
               end
            end
         end
      end
   end

   // LLR scaler
   qmld_llr_res_type llr_res;

   qmld_llr_unit #(.DW(DW)) u_llr (
      .clock  (clock),
      .reset  (reset),
      .start  (llr_start),
      .min0   (min0_ff[pos_c]),
      .min1   (min1_ff[pos_c]),
      .valid0 (v0_ff[pos_c]),
      .valid1 (v1_ff[pos_c]),
      .scale  (scale_ff),
      .res    (llr_res)
   );

   assign near_x = LBW'(near_ff);

   // Next state and controls
   always_comb begin
      state_in     = state_ff;
      ord_in       = ord_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      rd_en        = 1'b0;
      rd_tag_in    = '0;
      llr_start    = 1'b0;
      clear_mins   = 1'b0;
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_data.req_type == REQ_DEMOD) begin
               state_in   = ST_SCAN;
               ord_in     = ord_c;
               cnt_in     = '0;
               clear_mins = 1'b1;
            end
         end
         ST_SCAN: begin
            rd_en          = 1'b1;
            rd_tag_in.valid = 1'b1;
            rd_tag_in.last = (cnt_ff == last_addr);
            cnt_in         = cnt_ff + AW'(1);
            if (cnt_ff == last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (d_tag.valid && d_tag.last) begin
               state_in = ST_LLR_START;
               bit_in   = '0;
            end
         end
         ST_LLR_START: begin
            llr_start = 1'b1;
            state_in  = ST_LLR_WAIT;
         end
         ST_LLR_WAIT: begin
            if (llr_res.done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            // The output register takes the word once its previous word has left.
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               if (last_bit_c) begin
                  state_in = ST_IDLE;
               end else begin
                  bit_in   = bit_ff + IW'(1);
                  state_in = ST_LLR_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         v0_ff        <= '0;
         v1_ff        <= '0;
         best_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_tag_ff    <= rd_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         best_v_ff    <= best_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff  <= ord_in;
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
      min0_ff <= min0_in;
      min1_ff <= min1_in;
      best_ff <= best_in;
      near_ff <= near_in;
      if (accept) begin
         rx_i_ff <= SW'($unsigned(req_data.rx_i));
         rx_q_ff <= SW'($unsigned(req_data.rx_q));
      end
      if (load_rsp) begin
         rsp_data_ff.bit_index <= BIT_IDX_W'(bit_ff);
         rsp_data_ff.hard_bit  <= mode_ff ? llr_res.hard : near_x[pos_c];
         rsp_data_ff.llr       <= llr_res.llr;
         rsp_data_ff.last_bit  <= last_bit_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ bench/llr_word_checker.sv @@
// Result checker for the QAM max-log soft demapper: it watches the request,
// result and register ports, predicts every result word and compares it.
// Depends on qmld_pkg for the word types, register codes and LLR limits.
`timescale 1ns / 1ps

module llr_word_checker import qmld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_word_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    error_count,
   output int                    pending_count,
   output int                    words_checked
);

   localparam int SYM_BITS_MAX = 6;
   localparam int POINTS_MAX   = 1 << SYM_BITS_MAX;

   logic signed [FIELD_W-1:0] point_i_tbl [POINTS_MAX];
   logic signed [FIELD_W-1:0] point_q_tbl [POINTS_MAX];
   logic [LABEL_W-1:0]        label_tbl   [POINTS_MAX];

   logic [ORDER_W-1:0] order_cfg;
   logic               mode_cfg;
   logic [SCALE_W-1:0] scale_cfg;

   rsp_word_type expected_bits [$];
   int           mismatches;
   int           checked;

   // Saturated (min0 - min1) * scale >> 16, rounding toward minus infinity.
   function automatic logic [LLR_W-1:0] scaled_llr(longint min0, bit has0,
                                                   longint min1, bit has1,
                                                   longint scale);
      longint mag;
      longint prod;
      if (!has1) return LLR_NEG_MAX;
      if (!has0) return LLR_POS_MAX;
      if (scale == 0) return '0;
      if (min0 >= min1) begin
         mag  = min0 - min1;
         prod = (mag * scale) >> LLR_SHIFT;
         if (prod > 64'sd8388607) return LLR_POS_MAX;
         return prod[LLR_W-1:0];
      end
      mag  = min1 - min0;
      prod = mag * scale;
      prod = (prod >> LLR_SHIFT) + (((prod & 64'hFFFF) != 0) ? 1 : 0);
      if (prod > 64'sd8388608) return LLR_NEG_MAX;
      prod = -prod;
      return prod[LLR_W-1:0];
   endfunction

   // Searches the table for one received sample and queues one word per bit.
   function automatic void predict_symbol_bits(logic signed [FIELD_W-1:0] rx_i,
                                               logic signed [FIELD_W-1:0] rx_q);
      int                 n_bits;
      int                 p;
      int                 b;
      int                 lbit;
      longint             d_i;
      longint             d_q;
      longint             sq_dist;
      longint             best;
      longint             min_dist [2][SYM_BITS_MAX];
      bit                 seen     [2][SYM_BITS_MAX];
      logic [LABEL_W-1:0] near_label;
      rsp_word_type       w;
      if (order_cfg == 0) n_bits = 1;
      else if (order_cfg > SYM_BITS_MAX) n_bits = SYM_BITS_MAX;
      else n_bits = order_cfg;
      best       = 0;
      near_label = '0;
      for (b = 0; b < SYM_BITS_MAX; b++) begin
         seen[0][b]     = 1'b0;
         seen[1][b]     = 1'b0;
         min_dist[0][b] = 0;
         min_dist[1][b] = 0;
      end
      for (p = 0; p < (1 << n_bits); p++) begin
         d_i = longint'(point_i_tbl[p]) - longint'(rx_i);
         d_q = longint'(point_q_tbl[p]) - longint'(rx_q);
         sq_dist = d_i * d_i + d_q * d_q;
         if (p == 0 || sq_dist < best) begin
            best       = sq_dist;
            near_label = label_tbl[p];
         end
         for (b = 0; b < n_bits; b++) begin
            lbit = label_tbl[p][n_bits-1-b];
            if (!seen[lbit][b] || sq_dist < min_dist[lbit][b]) begin
               min_dist[lbit][b] = sq_dist;
               seen[lbit][b]     = 1'b1;
            end
         end
      end
      for (b = 0; b < n_bits; b++) begin
         w.bit_index = BIT_IDX_W'(b);
         w.llr = scaled_llr(min_dist[0][b], seen[0][b], min_dist[1][b], seen[1][b],
                            longint'(scale_cfg));
         if (mode_cfg) begin
            if (!seen[1][b]) w.hard_bit = 1'b0;
            else if (!seen[0][b]) w.hard_bit = 1'b1;
            else w.hard_bit = (min_dist[0][b] > min_dist[1][b]);
         end else begin
            w.hard_bit = near_label[n_bits-1-b];
         end
         w.last_bit = (b == n_bits - 1);
         expected_bits.push_back(w);
      end
   endfunction

   task automatic compare_word(rsp_word_type got);
      rsp_word_type want;
      if (expected_bits.size() == 0) begin
         $error("Result word with nothing expected: bit_index %0d llr %0d",
                got.bit_index, got.llr);
         mismatches++;
      end else begin
         want = expected_bits.pop_front();
         checked++;
         if (got.bit_index !== want.bit_index) begin
            $error("bit_index: expected %0d, got %0d", want.bit_index, got.bit_index);
            mismatches++;
         end
         if (got.hard_bit !== want.hard_bit) begin
            $error("hard_bit: expected %0d, got %0d", want.hard_bit, got.hard_bit);
            mismatches++;
         end
         if (got.llr !== want.llr) begin
            $error("llr: expected %0d, got %0d", want.llr, got.llr);
            mismatches++;
         end
         if (got.last_bit !== want.last_bit) begin
            $error("last_bit: expected %0d, got %0d", want.last_bit, got.last_bit);
            mismatches++;
         end
      end
   endtask

   initial begin
      mismatches = 0;
      checked    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_bits.delete();
         order_cfg = ORDER_RESET;
         mode_cfg  = 1'b0;
         scale_cfg = SCALE_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_ORDER_LOG2: order_cfg = csr_pwdata[ORDER_W-1:0];
               REG_DEMOD_MODE: mode_cfg  = csr_pwdata[0];
               REG_LLR_SCALE:  scale_cfg = csr_pwdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) compare_word(rsp_data);
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_LOAD) begin
               point_i_tbl[req_data.point_index] = req_data.point_i;
               point_q_tbl[req_data.point_index] = req_data.point_q;
               label_tbl[req_data.point_index]   = req_data.point_label;
            end else begin
               predict_symbol_bits(req_data.rx_i, req_data.rx_q);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_bits.size();
      words_checked <= checked;
   end

endmodule

@@ bench/tb_qam_max_log_soft_demapper.sv @@
// Top of the QAM max-log soft demapper testbench: clock, reset, register
// writes and request stimulus, with the verdict at the end.
// Depends on qmld_pkg, the demapper RTL and llr_word_checker.
`timescale 1ns / 1ps

module tb_qam_max_log_soft_demapper;
   import qmld_pkg::*;

   localparam int SETTLE_CYCLES     = 160;
   localparam int CYCLE_LIMIT       = 500000;
   localparam int RANDOM_SEGMENTS   = 6;
   localparam int WORDS_PER_SEGMENT = 58;
   localparam int POINTS_MAX        = 64;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count;
   int pending_count;
   int words_checked;

   int cycle_count = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 65;
   int words_sent = 0;
   int samples_sent = 0;
   int settings_used = 0;
   int cur_order = 4;

   // Stimulus-side record of the table, used to aim samples near loaded points.
   int pt_i_rec [POINTS_MAX];
   int pt_q_rec [POINTS_MAX];
   bit point_loaded [POINTS_MAX];

   qam_max_log_soft_demapper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   llr_word_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .words_checked (words_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("Timed out after %0d cycles with %0d result words outstanding",
                cycle_count, pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int points_searched(int order);
      if (order == 0) return 2;
      if (order > 6) return POINTS_MAX;
      return 1 << order;
   endfunction

   function automatic logic signed [FIELD_W-1:0] clamp16(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[FIELD_W-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] rand_coord();
      int t;
      case ($urandom_range(0, 7))
         0: t = $urandom_range(0, 1) ? 32767 : -32768;
         1, 2, 3: t = $urandom_range(0, 65535) - 32768;
         default: t = $urandom_range(0, 12000) - 6000;
      endcase
      return t[FIELD_W-1:0];
   endfunction

   // Every field gets random content; the caller overwrites the live ones.
   function automatic req_word_type raw_word();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type make_load(int idx, logic signed [FIELD_W-1:0] pi,
                                              logic signed [FIELD_W-1:0] pq,
                                              logic [LABEL_W-1:0] label);
      req_word_type w;
      w = raw_word();
      w.req_type    = REQ_LOAD;
      w.point_index = INDEX_W'(idx);
      w.point_i     = pi;
      w.point_q     = pq;
      w.point_label = label;
      pt_i_rec[idx]     = pi;
      pt_q_rec[idx]     = pq;
      point_loaded[idx] = 1'b1;
      return w;
   endfunction

   function automatic req_word_type make_demod(logic signed [FIELD_W-1:0] ri,
                                               logic signed [FIELD_W-1:0] rq);
      req_word_type w;
      w = raw_word();
      w.req_type = REQ_DEMOD;
      w.rx_i     = ri;
      w.rx_q     = rq;
      return w;
   endfunction

   // Samples mostly lie around loaded points; a demodulate word is only
   // made once every point in the searched range has been loaded.
   function automatic req_word_type next_random_word();
      int n;
      int p;
      int hole;
      n = points_searched(cur_order);
      hole = -1;
      for (p = n - 1; p >= 0; p--) if (!point_loaded[p]) hole = p;
      if ($urandom_range(0, 99) < 35) begin
         if ($urandom_range(0, 99) < 70) p = $urandom_range(0, n - 1);
         else p = $urandom_range(0, POINTS_MAX - 1);
         return make_load(p, rand_coord(), rand_coord(), LABEL_W'($urandom_range(0, 63)));
      end
      if (hole >= 0)
         return make_load(hole, rand_coord(), rand_coord(), LABEL_W'($urandom_range(0, 63)));
      if ($urandom_range(0, 99) < 70) begin
         p = $urandom_range(0, n - 1);
         return make_demod(clamp16(pt_i_rec[p] + $urandom_range(0, 4000) - 2000),
                           clamp16(pt_q_rec[p] + $urandom_range(0, 4000) - 2000));
      end
      return make_demod(rand_coord(), rand_coord());
   endfunction

   task automatic send_word(req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (w.req_type == REQ_DEMOD) samples_sent++;
   endtask

   // Drops valid and waits for every expected word, then optionally lets the
   // block settle so that a register write finds it idle.
   task automatic wait_drained(int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_code, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_code, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int order, int mode, int scale);
      wait_drained(SETTLE_CYCLES);
      csr_write(REG_ORDER_LOG2, order);
      csr_write(REG_DEMOD_MODE, mode);
      csr_write(REG_LLR_SCALE, scale);
      cur_order = order;
      settings_used++;
   endtask

   initial begin
      int seg;
      int k;
      for (k = 0; k < POINTS_MAX; k++) point_loaded[k] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Four corner points of the sample range, then samples at the centre and corners.
      set_config(2, 0, 65536);
      send_word(make_load(0, 32767, 32767, 6'd0));
      send_word(make_load(1, -32768, 32767, 6'd1));
      send_word(make_load(2, -32768, -32768, 6'd2));
      send_word(make_load(3, 32767, -32768, 6'd3));
      send_word(make_demod(0, 0));
      send_word(make_demod(32767, 32767));
      send_word(make_demod(-32768, -32768));
      send_word(make_demod(-32768, 32767));
      send_word(make_load(63, 0, 0, 6'd63));

      // Soft decisions at full scale; then relabel so that the MSB is never one.
      set_config(2, 1, 24'hFFFFFF);
      send_word(make_demod(100, -200));
      send_word(make_load(1, 32767, 32767, 6'h3C));
      send_word(make_load(2, -32768, -32768, 6'h3D));
      send_word(make_load(3, 32767, -32768, 6'h01));
      send_word(make_demod(0, 0));
      send_word(make_demod(32767, -32768));

      // An order of zero searches two points; a zero scale still saturates
      // when one label value is missing, and gives zero on a distance tie.
      set_config(0, 1, 0);
      send_word(make_demod(5, 5));
      send_word(make_load(1, 32767, 32767, 6'h3F));
      send_word(make_demod(32767, 32767));

      // Two points at the same spot: the lower index wins the nearest search.
      set_config(1, 0, 1);
      send_word(make_demod(-32768, -32768));
      send_word(make_load(0, 32767, 32767, 6'h01));
      send_word(make_demod(0, 0));
      set_config(1, 1, 1);
      send_word(make_demod(-1, -1));

      for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         case (seg)
            0: set_config(1, 0, 24'hFFFFFF);
            1: set_config($urandom_range(2, 5), 1, $urandom_range(1, 4095));
            2: set_config(6, 0, $urandom_range(0, 24'hFFFFFF));
            3: set_config(7, 1, 1);
            4: set_config($urandom_range(0, 7), $urandom_range(0, 1), 65536);
            default: set_config(3, 1, $urandom_range(1, 24'hFFFFFF));
         endcase
         if (seg < 2) begin
            send_idle_pct = 37;
            recv_idle_pct = 65;
         end else if (seg < 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (k = 0; k < WORDS_PER_SEGMENT; k++) begin
            if (seg == 1 && k == WORDS_PER_SEGMENT / 2) wait_drained(0);
            send_word(next_random_word());
         end
      end

      wait_drained(SETTLE_CYCLES);
      $display("Sent %0d request words, %0d of them samples to demodulate.",
               words_sent, samples_sent);
      $display("Checked %0d result words across %0d register settings.",
               words_checked, settings_used);
      if (pending_count != 0)
         $error("%0d expected result words never arrived", pending_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
